// ----- rtl/core/brs_pkg.sv -----
// brs_pkg: shared types and defaults for the branch reservation station
// no dependencies; used by brs_select and branch_reservation_station

package brs_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int TAG_BITS_DEF = 5;

  localparam int REQ_W   = 3;
  localparam int TAG_W   = 5;
  localparam int OP_W    = 8;
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int CIDX_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_BCAST  = 3'd1,
    REQ_SQUASH = 3'd2,
    REQ_ACCEPT = 3'd3,
    REQ_QUERY  = 3'd4
  } req_e;

endpackage

// ----- rtl/core/brs_select.sv -----
// brs_select: oldest-ready pick over the station slots
// parallel pairwise tag compare, lower slot wins a tie; uses brs_pkg

module brs_select import brs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  parameter int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0]               elig_i,
  input  logic [SLOTS-1:0][TAG_BITS-1:0] tags_i,
  output logic                           valid_o,
  output logic [IDX_W-1:0]               index_o
);

  logic [SLOTS-1:0] win;

  always_comb begin
    win = '0;
    for (int i = 0; i < SLOTS; i++) begin
      win[i] = elig_i[i];
      for (int j = 0; j < SLOTS; j++) begin
        if (j != i && elig_i[j]) begin
          if (!((tags_i[i] < tags_i[j]) || ((tags_i[i] == tags_i[j]) && (i < j)))) begin
            win[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    index_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (win[i]) begin
        index_o = index_o | IDX_W'(i);
      end
    end
  end

  assign valid_o = |elig_i;

endmodule

// ----- rtl/core/branch_reservation_station.sv -----
// branch_reservation_station: top level of the branch reservation station
// a request is captured in the input register, and its result and result strobe are then
// registered in the result register
// throughput: one request per cycle, busy_o stays low; the receiver cannot stall
// reset: slots free and operand wait tags cleared, no result pending
// depends on brs_pkg and brs_select

module branch_reservation_station import brs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [TAG_W-1:0]  rob_tag_in_i,
  input  logic [OP_W-1:0]   op_code_i,
  input  logic [WORD_W-1:0] first_value_i,
  input  logic [TAG_W-1:0]  first_wait_i,
  input  logic [WORD_W-1:0] second_value_i,
  input  logic [TAG_W-1:0]  second_wait_i,
  input  logic [WORD_W-1:0] immediate_i,
  input  logic [WORD_W-1:0] instr_pc_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic              is_address_i,
  input  logic              is_control_i,
  output logic              out_valid_o,
  output logic              cand_valid_o,
  output logic [CIDX_W-1:0] cand_index_o,
  output logic [OP_W-1:0]   cand_op_o,
  output logic [WORD_W-1:0] cand_first_o,
  output logic [WORD_W-1:0] cand_second_o,
  output logic [TAG_W-1:0]  cand_tag_o,
  output logic [WORD_W-1:0] cand_pc_o,
  output logic [WORD_W-1:0] cand_imm_o,
  output logic              is_full_o,
  output logic              is_empty_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // input register
  logic              req_valid_q;
  logic [REQ_W-1:0]  req_type_q;
  logic [TAG_W-1:0]  rob_tag_q;
  logic [OP_W-1:0]   op_code_q;
  logic [WORD_W-1:0] first_value_q;
  logic [TAG_W-1:0]  first_wait_q;
  logic [WORD_W-1:0] second_value_q;
  logic [TAG_W-1:0]  second_wait_q;
  logic [WORD_W-1:0] immediate_q;
  logic [WORD_W-1:0] instr_pc_q;
  logic [SLOT_W-1:0] slot_index_q;
  logic              is_address_q;
  logic              is_control_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_type_q     <= req_type_i;
      rob_tag_q      <= rob_tag_in_i;
      op_code_q      <= op_code_i;
      first_value_q  <= first_value_i;
      first_wait_q   <= first_wait_i;
      second_value_q <= second_value_i;
      second_wait_q  <= second_wait_i;
      immediate_q    <= immediate_i;
      instr_pc_q     <= instr_pc_i;
      slot_index_q   <= slot_index_i;
      is_address_q   <= is_address_i;
      is_control_q   <= is_control_i;
    end
  end

  // slot state
  logic [SLOTS-1:0]                busy_q, busy_d;
  logic [SLOTS-1:0][TAG_BITS-1:0]  wait1_q, wait1_d;
  logic [SLOTS-1:0][TAG_BITS-1:0]  wait2_q, wait2_d;
  logic [SLOTS-1:0][TAG_BITS-1:0]  etag_q;
  logic [OP_W-1:0]                 eop_q    [SLOTS];
  logic [WORD_W-1:0]               eval1_q  [SLOTS];
  logic [WORD_W-1:0]               eval2_q  [SLOTS];
  logic [WORD_W-1:0]               eimm_q   [SLOTS];
  logic [WORD_W-1:0]               epc_q    [SLOTS];

  logic [TAG_BITS-1:0] tag;
  logic [TAG_BITS-1:0] push_w1;
  logic [TAG_BITS-1:0] push_w2;
  logic [WORD_W-1:0]   bcast_val;
  logic                bcast_en;
  logic                is_push;
  logic                is_squash;
  logic                is_accept;
  logic [SLOTS-1:0]    push_sel;
  logic [SLOTS-1:0]    wake1;
  logic [SLOTS-1:0]    wake2;
  logic [SLOTS-1:0]    elig;
  logic                acc_hit;
  logic [IdxW-1:0]     acc_idx;
  logic                sel_valid;
  logic [IdxW-1:0]     sel_idx;

  assign tag       = TAG_BITS'(rob_tag_q);
  assign push_w1   = TAG_BITS'(first_wait_q);
  assign push_w2   = TAG_BITS'(second_wait_q);
  assign bcast_val = is_control_q ? second_value_q : first_value_q;
  assign is_push   = req_valid_q && (req_type_q == REQ_PUSH);
  assign is_squash = req_valid_q && (req_type_q == REQ_SQUASH);
  assign is_accept = req_valid_q && (req_type_q == REQ_ACCEPT);
  assign bcast_en  = req_valid_q && (req_type_q == REQ_BCAST) && !is_address_q && (tag != '0);
  assign acc_idx   = IdxW'(slot_index_q);
  assign acc_hit   = is_accept && (32'(slot_index_q) < SLOTS) && busy_q[acc_idx];

  // lowest free slot for a push
  always_comb begin
    logic seen;
    seen     = 1'b0;
    push_sel = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!busy_q[i] && !seen) begin
        push_sel[i] = is_push;
        seen        = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wake1[i] = bcast_en && busy_q[i] && (wait1_q[i] == tag);
      wake2[i] = bcast_en && busy_q[i] && (wait2_q[i] == tag);
      elig[i]  = busy_q[i] && (wait1_q[i] == '0) && (wait2_q[i] == '0) &&
                 !(is_squash && (etag_q[i] >= tag));
    end
  end

  always_comb begin
    busy_d  = busy_q;
    wait1_d = wait1_q;
    wait2_d = wait2_q;
    case (req_type_q)
      REQ_PUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (push_sel[i]) begin
            busy_d[i]  = 1'b1;
            wait1_d[i] = push_w1;
            wait2_d[i] = push_w2;
          end
        end
      end
      REQ_BCAST: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (wake1[i]) wait1_d[i] = '0;
          if (wake2[i]) wait2_d[i] = '0;
        end
      end
      REQ_SQUASH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (is_squash && busy_q[i] && (etag_q[i] > tag)) begin
            busy_d[i]  = 1'b0;
            wait1_d[i] = '0;
            wait2_d[i] = '0;
          end
        end
      end
      REQ_ACCEPT: begin
        if (acc_hit) begin
          busy_d[acc_idx]  = 1'b0;
          wait1_d[acc_idx] = '0;
          wait2_d[acc_idx] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      wait1_q <= '0;
      wait2_q <= '0;
    end else if (req_valid_q) begin
      busy_q  <= busy_d;
      wait1_q <= wait1_d;
      wait2_q <= wait2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (push_sel[i]) begin
        etag_q[i]  <= tag;
        eop_q[i]   <= op_code_q;
        eval1_q[i] <= first_value_q;
        eval2_q[i] <= second_value_q;
        eimm_q[i]  <= immediate_q;
        epc_q[i]   <= instr_pc_q;
      end else begin
        if (wake1[i]) eval1_q[i] <= bcast_val;
        if (wake2[i]) eval2_q[i] <= bcast_val;
      end
    end
  end

  brs_select #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS),
    .IDX_W    (IdxW)
  ) u_select (
    .elig_i  (elig),
    .tags_i  (etag_q),
    .valid_o (sel_valid),
    .index_o (sel_idx)
  );

  // result register
  logic              out_valid_q;
  logic              cand_valid_q;
  logic [CIDX_W-1:0] cand_index_q;
  logic [OP_W-1:0]   cand_op_q;
  logic [WORD_W-1:0] cand_first_q;
  logic [WORD_W-1:0] cand_second_q;
  logic [TAG_W-1:0]  cand_tag_q;
  logic [WORD_W-1:0] cand_pc_q;
  logic [WORD_W-1:0] cand_imm_q;
  logic              is_full_q;
  logic              is_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      cand_valid_q  <= sel_valid;
      cand_index_q  <= sel_valid ? CIDX_W'(sel_idx) : '0;
      cand_op_q     <= sel_valid ? eop_q[sel_idx] : '0;
      cand_first_q  <= sel_valid ? eval1_q[sel_idx] : '0;
      cand_second_q <= sel_valid ? eval2_q[sel_idx] : '0;
      cand_tag_q    <= sel_valid ? TAG_W'(etag_q[sel_idx]) : '0;
      cand_pc_q     <= sel_valid ? epc_q[sel_idx] : '0;
      cand_imm_q    <= sel_valid ? eimm_q[sel_idx] : '0;
      is_full_q     <= &busy_q;
      is_empty_q    <= ~|busy_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cand_valid_o  = cand_valid_q;
  assign cand_index_o  = cand_index_q;
  assign cand_op_o     = cand_op_q;
  assign cand_first_o  = cand_first_q;
  assign cand_second_o = cand_second_q;
  assign cand_tag_o    = cand_tag_q;
  assign cand_pc_o     = cand_pc_q;
  assign cand_imm_o    = cand_imm_q;
  assign is_full_o     = is_full_q;
  assign is_empty_o    = is_empty_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 out_valid_o)
    else $error("request did not produce a result strobe");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("station reported full and empty together");

  a_cand_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cand_valid_o) |-> !is_empty_o)
    else $error("candidate reported from an empty station");

  a_push_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> ($countones(busy_q) <= $countones($past(busy_q)) + 1))
    else $error("more than one slot taken by a request");
`endif

endmodule
